### rtl/fgkt_pkg.sv
// Shared types and constants for the fixed-gain Kalman tracker.
package fgkt_pkg;

   // Configuration register indexes (byte address = 4 * index)
   localparam logic [1:0] CSR_STEP_DT  = 2'd0;
   localparam logic [1:0] CSR_POS_GAIN = 2'd1;
   localparam logic [1:0] CSR_VEL_GAIN = 2'd2;

   localparam logic [7:0] STEP_DT_RST  = 8'd16;
   localparam logic [4:0] POS_GAIN_RST = 5'd8;
   localparam logic [4:0] VEL_GAIN_RST = 5'd4;

   // Datapath operations
   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_MUL_DT = 3'd1;  // prod = dt * v
   localparam logic [2:0] OP_PRED   = 3'd2;  // p' and v'
   localparam logic [2:0] OP_INNOV  = 3'd3;  // i = z - p'
   localparam logic [2:0] OP_MUL_KP = 3'd4;  // prod = kp * i
   localparam logic [2:0] OP_UPD_P  = 3'd5;  // p update, prod = kv * i
   localparam logic [2:0] OP_UPD_V  = 3'd6;  // v update

   typedef struct packed {
      logic       load;     // capture measurements
      logic       axis_y;   // 0: x axis, 1: y axis
      logic [2:0] op;
      logic       publish;  // copy state into the output register
   } cmd_type;

endpackage

### rtl/fgkt_ctrl.sv
// Sequencer for the tracker: steps both axes through the shared multiplier.
module fgkt_ctrl
   import fgkt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    out_free,
   output logic    req_ready,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL_DT = 3'd1;
   localparam logic [2:0] S_PRED   = 3'd2;
   localparam logic [2:0] S_INNOV  = 3'd3;
   localparam logic [2:0] S_MUL_KP = 3'd4;
   localparam logic [2:0] S_UPD_P  = 3'd5;
   localparam logic [2:0] S_UPD_V  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.axis_y  = axis_ff;
      cmd.op      = OP_NOP;
      cmd.publish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // ready is high here, so valid alone means the item is taken
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               axis_in  = 1'b0;
               state_in = S_MUL_DT;
            end
         end
         S_MUL_DT: begin
            cmd.op   = OP_MUL_DT;
            state_in = S_PRED;
         end
         S_PRED: begin
            cmd.op   = OP_PRED;
            state_in = S_INNOV;
         end
         S_INNOV: begin
            cmd.op   = OP_INNOV;
            state_in = S_MUL_KP;
         end
         S_MUL_KP: begin
            cmd.op   = OP_MUL_KP;
            state_in = S_UPD_P;
         end
         S_UPD_P: begin
            cmd.op   = OP_UPD_P;
            state_in = S_UPD_V;
         end
         S_UPD_V: begin
            cmd.op = OP_UPD_V;
            if (axis_ff) begin
               state_in = S_DONE;
            end else begin
               axis_in  = 1'b1;
               state_in = S_MUL_DT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/fgkt_dpath.sv
// Tracker datapath: state registers, shared multiplier and adders.
module fgkt_dpath
   import fgkt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic signed [31:0]           meas_x,
   input  logic signed [31:0]           meas_y,
   input  logic [7:0]                   step_dt,
   input  logic [4:0]                   pos_gain,
   input  logic [4:0]                   vel_gain,
   output logic signed [DATA_WIDTH-1:0] pos_x,
   output logic signed [DATA_WIDTH-1:0] pos_y,
   output logic signed [DATA_WIDTH-1:0] vel_x,
   output logic signed [DATA_WIDTH-1:0] vel_y
);

   localparam logic [DATA_WIDTH-1:0] VEL_X_RST = DATA_WIDTH'(2) << FRAC_BITS;
   localparam logic [DATA_WIDTH-1:0] VEL_Y_RST = DATA_WIDTH'(1) << FRAC_BITS;

   logic signed [DATA_WIDTH-1:0] px_ff, py_ff, vx_ff, vy_ff;
   logic signed [DATA_WIDTH-1:0] zx_ff, zy_ff;
   logic signed [DATA_WIDTH-1:0] prod_ff, pp_ff, vp_ff, innov_ff;

   logic signed [DATA_WIDTH-1:0] p_sel, v_sel, z_sel;
   logic signed [DATA_WIDTH-1:0] pred_sum, pp_val, vp_val, prod_asr, new_val;
   logic [7:0]                   mul_a;
   logic [DATA_WIDTH-1:0]        mul_b, mul_out;

   assign p_sel = cmd.axis_y ? py_ff : px_ff;
   assign v_sel = cmd.axis_y ? vy_ff : vx_ff;
   assign z_sel = cmd.axis_y ? zy_ff : zx_ff;

   // prediction: p' = (U*p + dt*v) >>> F, v' = (U*v) >>> F, all wrapping
   assign pred_sum = (p_sel <<< FRAC_BITS) + prod_ff;
   assign pp_val   = pred_sum >>> FRAC_BITS;
   assign vp_val   = DATA_WIDTH'(v_sel <<< FRAC_BITS) >>> FRAC_BITS;
   assign prod_asr = prod_ff >>> FRAC_BITS;
   assign new_val  = (cmd.op == OP_UPD_P) ? (pp_ff + prod_asr) : (vp_ff + prod_asr);

   // shared multiplier; only the low bits are kept, so signedness is moot
   always_comb begin
      mul_a = step_dt;
      mul_b = v_sel;
      case (cmd.op)
         OP_MUL_KP: begin
            mul_a = {3'b000, pos_gain};
            mul_b = innov_ff;
         end
         OP_UPD_P: begin
            mul_a = {3'b000, vel_gain};
            mul_b = innov_ff;
         end
         default: begin
            mul_a = step_dt;
            mul_b = v_sel;
         end
      endcase
   end

   assign mul_out = mul_b * DATA_WIDTH'(mul_a);

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         vx_ff <= VEL_X_RST;
         vy_ff <= VEL_Y_RST;
      end else begin
         unique case (cmd.op)
            OP_UPD_P: begin
               if (cmd.axis_y) py_ff <= new_val;
               else            px_ff <= new_val;
            end
            OP_UPD_V: begin
               if (cmd.axis_y) vy_ff <= new_val;
               else            vx_ff <= new_val;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zx_ff <= DATA_WIDTH'(meas_x);
         zy_ff <= DATA_WIDTH'(meas_y);
      end
      unique case (cmd.op) inside
         OP_MUL_DT, OP_MUL_KP, OP_UPD_P: begin
            prod_ff <= mul_out;
         end
         OP_PRED: begin
            pp_ff <= pp_val;
            vp_ff <= vp_val;
         end
         OP_INNOV: begin
            innov_ff <= z_sel - pp_ff;
         end
         default: begin
         end
      endcase
   end

   assign pos_x = px_ff;
   assign pos_y = py_ff;
   assign vel_x = vx_ff;
   assign vel_y = vy_ff;

endmodule

### rtl/fixed_gain_kalman_tracker.sv
// A request item is accepted in the idle state; the sequencer then steps the x axis
// and then the y axis, and publishes the result once the output register is free.
// Each axis takes six steps (three of them on the single shared multiplier); the
// next item is not accepted until the previous one has been published.
// The next item is accepted while the previous result waits in the output register.
// Reset (synchronous, active high): pos = 0, vel_x = 2.0, vel_y = 1.0,
// step_dt = 16, pos_gain = 8, vel_gain = 4; no item pending.
module fixed_gain_kalman_tracker
   import fgkt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 4
) (
   input  logic          clock,
   input  logic          reset,
   // request: [31:0] meas_x, [63:32] meas_y
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,
   // result: [31:0] est_px, [63:32] est_py, [95:64] est_vx, [127:96] est_vy,
   // [135:128] px_units_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,
   // configuration
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   // ---------------- configuration registers ----------------
   logic [7:0] step_dt_ff;
   logic [4:0] pos_gain_ff, vel_gain_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_dt_ff  <= STEP_DT_RST;
         pos_gain_ff <= POS_GAIN_RST;
         vel_gain_ff <= VEL_GAIN_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_STEP_DT:  step_dt_ff  <= csr_pwdata[7:0];
            CSR_POS_GAIN: pos_gain_ff <= csr_pwdata[4:0];
            CSR_VEL_GAIN: vel_gain_ff <= csr_pwdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_STEP_DT:  csr_prdata = {24'd0, step_dt_ff};
         CSR_POS_GAIN: csr_prdata = {27'd0, pos_gain_ff};
         CSR_VEL_GAIN: csr_prdata = {27'd0, vel_gain_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer and datapath ----------------
   cmd_type                      cmd;
   logic                         out_free;
   logic signed [DATA_WIDTH-1:0] pos_x, pos_y, vel_x, vel_y, px_units;

   fgkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   fgkt_dpath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .meas_x   (req_tdata[31:0]),
      .meas_y   (req_tdata[63:32]),
      .step_dt  (step_dt_ff),
      .pos_gain (pos_gain_ff),
      .vel_gain (vel_gain_ff),
      .pos_x    (pos_x),
      .pos_y    (pos_y),
      .vel_x    (vel_x),
      .vel_y    (vel_y)
   );

   // ---------------- output register ----------------
   // Holds a finished result so the datapath can start on the next item.
   logic         rsp_valid_ff;
   logic [135:0] rsp_data_ff;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign px_units = pos_x >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff <= {px_units[7:0], 32'(vel_y), 32'(vel_x), 32'(pos_y), 32'(pos_x)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### verif/tb.sv
// Self-checking testbench for the fixed-gain Kalman tracker: streams measurements, checks estimates.
`timescale 1ns / 100ps

module tb;
   import fgkt_pkg::*;

   localparam int FRAC        = 4;         // Q4 fraction bits
   localparam int CYCLE_LIMIT = 300000;    // many times the slowest legal run
   localparam int HOLD_CYCLES = 400;       // long receiver hold-off
   localparam int RAND_ITEMS  = 182;       // random items per traffic phase
   localparam int DRAIN_WAIT  = 20;        // wait after the last phase, with margin

   // address with no register behind it; a write there must change nothing
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // boundary values of a 32-bit Q4 position
   localparam logic [31:0] CORNER [8] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0100
   };

   // one expected estimate, same layout as rsp_tdata
   typedef struct packed {
      logic [7:0]  units;
      logic [31:0] vy;
      logic [31:0] vx;
      logic [31:0] py;
      logic [31:0] px;
   } track_est_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;     // [31:0] meas_x, [63:32] meas_y
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;          // px, py, vx, vy, px_units_byte
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [3:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // tracker state and register copies kept by the testbench
   logic [31:0]   trk_px, trk_py, trk_vx, trk_vy;
   logic [7:0]    cfg_dt = STEP_DT_RST;
   logic [4:0]    cfg_kp = POS_GAIN_RST;
   logic [4:0]    cfg_kv = VEL_GAIN_RST;

   logic [63:0]   meas_q[$];          // measurements waiting for the driver
   track_est_type est_q[$];           // estimates owed by the block

   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_goal = 0;
   int            hold_count = 0;
   int            cycle_cnt = 0;
   int            n_errors = 0;
   int            n_meas_sent = 0;
   int            n_est_checked = 0;
   int            n_csr_writes = 0;

   fixed_gain_kalman_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Tracker arithmetic: everything wraps at 32 bits, shifts are
   // arithmetic. Gains and dt are zero-extended before multiplying.
   // ---------------------------------------------------------------
   function automatic logic [31:0] q4_shift(input logic [31:0] v);
      return $signed(v) >>> FRAC;
   endfunction

   function automatic void filter_axis(inout logic [31:0] pos, inout logic [31:0] vel,
                                       input logic [31:0] meas);
      logic [31:0] pos_pred, vel_pred, innov;
      pos_pred = q4_shift((pos << FRAC) + {24'd0, cfg_dt} * vel);
      vel_pred = q4_shift(vel << FRAC);   // drops the top four bits of vel
      innov    = meas - pos_pred;
      pos      = pos_pred + q4_shift({27'd0, cfg_kp} * innov);
      vel      = vel_pred + q4_shift({27'd0, cfg_kv} * innov);
   endfunction

   // advance the tracker by one accepted measurement and queue the estimate
   function automatic void track_measurement(input logic [63:0] meas);
      track_est_type est;
      logic [31:0]   units;
      filter_axis(trk_px, trk_vx, meas[31:0]);
      filter_axis(trk_py, trk_vy, meas[63:32]);
      units     = q4_shift(trk_px);
      est.px    = trk_px;
      est.py    = trk_py;
      est.vx    = trk_vx;
      est.vy    = trk_vy;
      est.units = units[7:0];
      est_q.push_back(est);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d (0x%h), got %0d (0x%h)", name,
                $signed(want), want, $signed(got), got);
         n_errors++;
      end
   endfunction

   function automatic void check_estimate(input track_est_type got);
      track_est_type want;
      if (est_q.size() == 0) begin
         $error("estimate with no measurement pending: 0x%h", got);
         n_errors++;
         return;
      end
      want = est_q.pop_front();
      check_field("est_px", want.px, got.px);
      check_field("est_py", want.py, got.py);
      check_field("est_vx", want.vx, got.vx);
      check_field("est_vy", want.vy, got.vy);
      check_field("px_units_byte", {24'd0, want.units}, {24'd0, got.units});
      n_est_checked++;
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers the head of meas_q; holds it until accepted.
   // Prediction happens at the accepting edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_measurement(req_tdata);
            void'(meas_q.pop_front());
            n_meas_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // item still on offer, keep it steady
         end else if (meas_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= meas_q[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (hold_count < hold_goal) hold_count <= hold_count + 1;
   end

   // Monitor: checks each accepted estimate and throttles rsp_tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_estimate(rsp_tdata);
         if (hold_count < hold_goal) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void queue_meas(input logic [31:0] mx, input logic [31:0] my);
      meas_q.push_back({my, mx});
   endfunction

   // APB write: setup, then access; register lands when pready is seen
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // registers keep only their low bits
      case (idx)
         CSR_STEP_DT:  cfg_dt = data[7:0];
         CSR_POS_GAIN: cfg_kp = data[4:0];
         CSR_VEL_GAIN: cfg_kv = data[4:0];
         default: ;
      endcase
      n_csr_writes++;
   endtask

   task automatic set_gains(input logic [31:0] dt, input logic [31:0] kp,
                            input logic [31:0] kv);
      csr_write(CSR_STEP_DT, dt);
      csr_write(CSR_POS_GAIN, kp);
      csr_write(CSR_VEL_GAIN, kv);
   endtask

   // every measurement yields one estimate, so an empty est_q means idle
   task automatic wait_drained();
      while (meas_q.size() != 0 || req_tvalid || est_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_traffic(input int send_idle, input int recv_stall);
      @(negedge clock);
      send_idle_pct  = send_idle;
      recv_stall_pct = recv_stall;
   endtask

   // Mostly smooth target tracks (position + velocity + small noise),
   // some new tracks, and about a quarter raw random garbage.
   task automatic queue_random(input int count);
      int tx, ty, tvx, tvy;
      tx  = $urandom_range(0, 2 ** 21) - 2 ** 20;
      ty  = $urandom_range(0, 2 ** 21) - 2 ** 20;
      tvx = $urandom_range(0, 512) - 256;
      tvy = $urandom_range(0, 512) - 256;
      repeat (count) begin
         if ($urandom_range(99) < 6) begin
            tx  = $urandom_range(0, 2 ** 21) - 2 ** 20;
            ty  = $urandom_range(0, 2 ** 21) - 2 ** 20;
            tvx = $urandom_range(0, 512) - 256;
            tvy = $urandom_range(0, 512) - 256;
         end
         if ($urandom_range(99) < 75) begin
            tx += tvx;
            ty += tvy;
            queue_meas(tx + $urandom_range(0, 64) - 32, ty + $urandom_range(0, 64) - 32);
         end else begin
            queue_meas($urandom, $urandom);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      bit leftover;
      leftover = 1'b0;
      // post-reset state of the tracker
      trk_px = '0;
      trk_py = '0;
      trk_vx = 32'd32;
      trk_vy = 32'd16;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: boundary positions with reset gains
      set_traffic(0, 0);
      for (int i = 0; i < 8; i++) queue_meas(CORNER[i], CORNER[7 - i]);
      queue_meas(32'h0000_0120, 32'h0000_0210);
      queue_meas(32'h0000_0140, 32'h0000_0220);
      wait_drained();

      // largest gains and dt; upper bits of pwdata must be dropped,
      // and a write to the unmapped slot must not disturb anything
      set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      csr_write(CSR_UNMAPPED, $urandom);
      for (int i = 0; i < 8; i++) queue_meas(CORNER[i], CORNER[(i + 3) % 8]);
      wait_drained();

      // all-zero gains and dt, junk above the register widths
      set_gains(32'hFFFF_FF00, 32'hFFFF_FFE0, 32'h0000_00E0);
      for (int i = 0; i < 5; i++) queue_meas(CORNER[i], CORNER[i + 3]);
      wait_drained();

      // random traffic, one handshake mix per phase
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_gains($urandom_range(0, 255), $urandom_range(0, 31), $urandom_range(0, 31));
            1: set_gains(32'd255, 32'd31, 32'd0);
            2: set_gains($urandom, $urandom, $urandom);
            default: set_gains(32'd0, 32'd0, 32'd31);
         endcase
         case (ph)
            0: set_traffic(0, 0);
            1: set_traffic(64, 0);
            2: set_traffic(0, 64);
            default: set_traffic(22, 22);
         endcase
         // back-pressure: receiver stops while the sender keeps pushing
         if (ph == 0) hold_goal = hold_goal + HOLD_CYCLES;
         queue_random(RAND_ITEMS);
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(negedge clock);
      if (est_q.size() != 0) begin
         $error("%0d estimates never arrived", est_q.size());
         leftover = 1'b1;
      end
      $display("coverage: %0d measurements sent, %0d estimates checked, %0d register writes",
               n_meas_sent, n_est_checked, n_csr_writes);
      $display("  gain extremes, unmapped write, four stall mixes, one long output hold-off");
      if (n_errors == 0 && !leftover) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### files.f
rtl/fgkt_pkg.sv
rtl/fgkt_ctrl.sv
rtl/fgkt_dpath.sv
rtl/fixed_gain_kalman_tracker.sv
verif/tb.sv
